/* rtl/core/bpc_pkg.sv */
// bpc_pkg: shared constants, types and helpers for the pressure compensation core.
// Used by bpc_div and barometric_pressure_compensation_core; no dependencies.
package bpc_pkg;

	localparam int DIV_STEPS = 32;

	// configuration register indexes
	localparam logic [2:0] REG_AC123 = 3'd0;
	localparam logic [2:0] REG_AC456 = 3'd1;
	localparam logic [2:0] REG_B1B2  = 3'd2;
	localparam logic [2:0] REG_MCMD  = 3'd3;
	localparam logic [2:0] REG_OSS   = 3'd4;

	localparam logic [31:0] B6_OFS    = 32'd4000;
	localparam logic [31:0] K_3038    = 32'd3038;
	localparam logic [31:0] K_7357    = 32'd7357;
	localparam logic [31:0] K_3791    = 32'd3791;
	localparam logic [31:0] K_50000   = 32'd50000;
	localparam logic [31:0] K_32768   = 32'd32768;

	// sideband that rides along the temperature divider
	typedef struct packed {
		logic        v;
		logic        flt;
		logic        neg;
		logic [31:0] x1;
		logic [18:0] up;
	} tside_t;

	// sideband that rides along the pressure divider
	typedef struct packed {
		logic        v;
		logic        flt;
		logic        psh;
		logic [27:0] temp;
	} pside_t;

	// arithmetic right shift of a 32-bit pattern
	function automatic logic [31:0] sra(input logic [31:0] v, input logic [4:0] s);
		sra = $unsigned($signed(v) >>> s);
	endfunction

	// sign-extend a 16-bit word
	function automatic logic [31:0] sx16(input logic [15:0] w);
		sx16 = {{16{w[15]}}, w};
	endfunction

endpackage

/* rtl/core/bpc_div.sv */
// bpc_div: pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on bpc_pkg. All stages advance on en.
module bpc_div (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic [31:0] quo
);

	logic [31:0] rem_s [bpc_pkg::DIV_STEPS];
	logic [31:0] nq_s  [bpc_pkg::DIV_STEPS];
	logic [31:0] dn_s  [bpc_pkg::DIV_STEPS];
	logic [31:0] rem_n [bpc_pkg::DIV_STEPS];
	logic [31:0] nq_n  [bpc_pkg::DIV_STEPS];
	logic [31:0] dn_n  [bpc_pkg::DIV_STEPS];

	always_comb begin
		logic [31:0] r_in;
		logic [31:0] q_in;
		logic [31:0] d_in;
		logic [32:0] pr;
		for (int k = 0; k < bpc_pkg::DIV_STEPS; k++) begin
			if (k == 0) begin
				r_in = '0;
				q_in = num;
				d_in = den;
			end else begin
				r_in = rem_s[k-1];
				q_in = nq_s[k-1];
				d_in = dn_s[k-1];
			end
			pr = {r_in, q_in[31]};
			if (pr >= {1'b0, d_in}) begin
				rem_n[k] = 32'(pr - {1'b0, d_in});
				nq_n[k]  = {q_in[30:0], 1'b1};
			end else begin
				rem_n[k] = pr[31:0];
				nq_n[k]  = {q_in[30:0], 1'b0};
			end
			dn_n[k] = d_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < bpc_pkg::DIV_STEPS; k++) begin
				rem_s[k] <= rem_n[k];
				nq_s[k]  <= nq_n[k];
				dn_s[k]  <= dn_n[k];
			end
		end
	end

	assign quo = nq_s[bpc_pkg::DIV_STEPS-1];

endmodule

/* rtl/core/barometric_pressure_compensation_core.sv */
// barometric_pressure_compensation_core: integer temperature/pressure compensation.
// Depends on bpc_pkg and bpc_div (two instances: temperature and pressure).
//
//  channel | signals                                    | direction
//  in      | in_valid, in_stall, raw_temperature/pressure | request in
//  out     | out_valid, out_stall, temperature_tenths,    | request out
//          | pressure_pa, divide_fault                    |
//  cfg     | cfg_write, cfg_index, cfg_data               | write in
//
// One request per cycle sustained while no stalled result holds the pipeline; the
// two dividers are bit-per-stage. Reset clears valid bits and configuration.
// A stalled result freezes the whole pipeline; in_stall rises only then.
module barometric_pressure_compensation_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        raw_temperature,
	input  logic [18:0]        raw_pressure,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [27:0] temperature_tenths,
	output logic signed [31:0] pressure_pa,
	output logic               divide_fault
);

	logic [47:0] ac123_q, ac456_q;
	logic [31:0] b1b2_q, mcmd_q;
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac123_q <= '0;
			ac456_q <= '0;
			b1b2_q  <= '0;
			mcmd_q  <= '0;
			oss_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bpc_pkg::REG_AC123: ac123_q <= cfg_data;
				bpc_pkg::REG_AC456: ac456_q <= cfg_data;
				bpc_pkg::REG_B1B2:  b1b2_q  <= cfg_data[31:0];
				bpc_pkg::REG_MCMD:  mcmd_q  <= cfg_data[31:0];
				bpc_pkg::REG_OSS:   oss_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = bpc_pkg::sx16(ac123_q[47:32]);
	assign ac2 = bpc_pkg::sx16(ac123_q[31:16]);
	assign ac3 = bpc_pkg::sx16(ac123_q[15:0]);
	assign ac4 = {16'b0, ac456_q[47:32]};
	assign ac5 = {16'b0, ac456_q[31:16]};
	assign ac6 = {16'b0, ac456_q[15:0]};
	assign b1  = bpc_pkg::sx16(b1b2_q[31:16]);
	assign b2  = bpc_pkg::sx16(b1b2_q[15:0]);
	assign mc  = bpc_pkg::sx16(mcmd_q[31:16]);
	assign md  = bpc_pkg::sx16(mcmd_q[15:0]);

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17;

	// payload
	logic [31:0] d_s1, m_s2, x1_s3, dv_s3, nm_s3;
	logic [31:0] an_s4, ad_s4, x1_s4;
	logic        neg_s4, flt_s4;
	logic [18:0] up_s1, up_s2, up_s3, up_s4;
	logic [31:0] b5_s5, b6_s6, sqm_s7, mac2_s7, mac3_s7;
	logic [31:0] sq_s8, x2_s8, x1b_s8, mb2_s9, mb1_s9, x2_s9, x1b_s9;
	logic [31:0] x3_s10, x3b_s10, b3_s11, t_s11, b4_s12, dd_s12;
	logic [31:0] b7_s13, b4_s13, num_s14, den_s14;
	logic        psh_s14;
	logic [31:0] p_s15, p_s16, mm1_s16, mm2_s16, p_s17, m3_s17, x2c_s17;
	logic [18:0] up_s5, up_s6, up_s7, up_s8, up_s9, up_s10, up_s11;
	logic [27:0] tp_s6, tp_s7, tp_s8, tp_s9, tp_s10, tp_s11, tp_s12, tp_s13, tp_s14;
	logic [27:0] tp_s15, tp_s16, tp_s17;
	logic        flt_s5, flt_s6, flt_s7, flt_s8, flt_s9, flt_s10, flt_s11, flt_s12;
	logic        flt_s13, flt_s14, flt_s15, flt_s16, flt_s17;

	bpc_pkg::tside_t tline_q [bpc_pkg::DIV_STEPS];
	bpc_pkg::pside_t pline_q [bpc_pkg::DIV_STEPS];
	bpc_pkg::tside_t tin;
	bpc_pkg::pside_t pin;
	logic [31:0] tq, pq;

	assign tin = '{v: v_s4, flt: flt_s4, neg: neg_s4, x1: x1_s4, up: up_s4};
	assign pin = '{v: v_s14, flt: flt_s14, psh: psh_s14, temp: tp_s14};

	bpc_div u_tdiv (.clk(clk), .en(en), .num(an_s4), .den(ad_s4), .quo(tq));
	bpc_div u_pdiv (.clk(clk), .en(en), .num(num_s14), .den(den_s14), .quo(pq));

	bpc_pkg::tside_t ts;
	bpc_pkg::pside_t ps;
	assign ts = tline_q[bpc_pkg::DIV_STEPS-1];
	assign ps = pline_q[bpc_pkg::DIV_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
			{v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17} <= '0;
			out_valid <= 1'b0;
			for (int k = 0; k < bpc_pkg::DIV_STEPS; k++) begin
				tline_q[k] <= '0;
				pline_q[k] <= '0;
			end
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= ts.v;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= ps.v;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			out_valid <= v_s17;
			tline_q[0] <= tin;
			pline_q[0] <= pin;
			for (int k = 1; k < bpc_pkg::DIV_STEPS; k++) begin
				tline_q[k] <= tline_q[k-1];
				pline_q[k] <= pline_q[k-1];
			end
		end
	end

	logic [31:0] cmp_x1, cmp_sum;
	assign cmp_x1  = bpc_pkg::sra(m3_s17, 5'd16);
	assign cmp_sum = bpc_pkg::sra(cmp_x1 + x2c_s17 + bpc_pkg::K_3791, 5'd4);

	always_ff @(posedge clk) begin
		if (en) begin
			// temperature front end
			d_s1  <= {16'b0, raw_temperature} - ac6;
			up_s1 <= raw_pressure;
			m_s2  <= d_s1 * ac5;
			up_s2 <= up_s1;
			x1_s3 <= bpc_pkg::sra(m_s2, 5'd15);
			dv_s3 <= bpc_pkg::sra(m_s2, 5'd15) + md;
			nm_s3 <= {mc[20:0], 11'b0};
			up_s3 <= up_s2;
			an_s4  <= nm_s3[31] ? 32'(-nm_s3) : nm_s3;
			ad_s4  <= dv_s3[31] ? 32'(-dv_s3) : dv_s3;
			neg_s4 <= nm_s3[31] ^ dv_s3[31];
			flt_s4 <= (dv_s3 == '0);
			x1_s4  <= x1_s3;
			up_s4  <= up_s3;
			// after temperature division
			b5_s5  <= ts.x1 + (ts.neg ? 32'(-tq) : tq);
			flt_s5 <= ts.flt;
			up_s5  <= ts.up;
			b6_s6  <= b5_s5 - bpc_pkg::B6_OFS;
			tp_s6  <= 28'(bpc_pkg::sra(b5_s5 + 32'd8, 5'd4));
			flt_s6 <= flt_s5;
			up_s6  <= up_s5;
			sqm_s7  <= b6_s6 * b6_s6;
			mac2_s7 <= ac2 * b6_s6;
			mac3_s7 <= ac3 * b6_s6;
			tp_s7 <= tp_s6; flt_s7 <= flt_s6; up_s7 <= up_s6;
			sq_s8  <= bpc_pkg::sra(sqm_s7, 5'd12);
			x2_s8  <= bpc_pkg::sra(mac2_s7, 5'd11);
			x1b_s8 <= bpc_pkg::sra(mac3_s7, 5'd13);
			tp_s8 <= tp_s7; flt_s8 <= flt_s7; up_s8 <= up_s7;
			mb2_s9 <= b2 * sq_s8;
			mb1_s9 <= b1 * sq_s8;
			x2_s9  <= x2_s8;
			x1b_s9 <= x1b_s8;
			tp_s9 <= tp_s8; flt_s9 <= flt_s8; up_s9 <= up_s8;
			x3_s10  <= bpc_pkg::sra(mb2_s9, 5'd11) + x2_s9;
			x3b_s10 <= bpc_pkg::sra(bpc_pkg::sra(mb1_s9, 5'd16) + x1b_s9 + 32'd2, 5'd2);
			tp_s10 <= tp_s9; flt_s10 <= flt_s9; up_s10 <= up_s9;
			b3_s11 <= bpc_pkg::sra((((ac1 << 2) + x3_s10) << oss_q) + 32'd2, 5'd2);
			t_s11  <= x3b_s10 + bpc_pkg::K_32768;
			tp_s11 <= tp_s10; flt_s11 <= flt_s10; up_s11 <= up_s10;
			b4_s12 <= (ac4 * t_s11) >> 15;
			dd_s12 <= {13'b0, up_s11} - b3_s11;
			tp_s12 <= tp_s11; flt_s12 <= flt_s11;
			b7_s13 <= dd_s12 * (bpc_pkg::K_50000 >> oss_q);
			b4_s13 <= b4_s12;
			tp_s13 <= tp_s12; flt_s13 <= flt_s12;
			// large b7 divides first and doubles after
			psh_s14 <= b7_s13[31];
			num_s14 <= b7_s13[31] ? b7_s13 : (b7_s13 << 1);
			den_s14 <= b4_s13;
			flt_s14 <= flt_s13 | (b4_s13 == '0);
			tp_s14  <= tp_s13;
			// after pressure division
			p_s15   <= ps.psh ? (pq << 1) : pq;
			flt_s15 <= ps.flt;
			tp_s15  <= ps.temp;
			mm1_s16 <= bpc_pkg::sra(p_s15, 5'd8) * bpc_pkg::sra(p_s15, 5'd8);
			mm2_s16 <= 32'd0 - bpc_pkg::K_7357 * p_s15;
			p_s16 <= p_s15; tp_s16 <= tp_s15; flt_s16 <= flt_s15;
			m3_s17  <= mm1_s16 * bpc_pkg::K_3038;
			x2c_s17 <= bpc_pkg::sra(mm2_s16, 5'd16);
			p_s17 <= p_s16; tp_s17 <= tp_s16; flt_s17 <= flt_s16;
			temperature_tenths <= flt_s17 ? '0 : $signed(tp_s17);
			pressure_pa        <= flt_s17 ? '0 : $signed(p_s17 + cmp_sum);
			divide_fault       <= flt_s17;
		end
	end

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_fault |-> temperature_tenths == 0 && pressure_pa == 0)
		else $error("fault result not zero");

	a_stall_only_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output hold");

	a_hold_keeps_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pressure_pa))
		else $error("held result lost");

endmodule

/* bench/tb_barometric_pressure_compensation_core.sv */
// Testbench for barometric_pressure_compensation_core: drives random and directed readings,
// predicts each compensated result in a scoreboard class and checks every output request.
// Depends on bpc_pkg for register indexes and the core RTL.
`timescale 1ns / 100ps

module tb_barometric_pressure_compensation_core;

	class comp_scoreboard;
		logic [47:0] ac123, ac456;
		logic [31:0] b1b2, mcmd;
		logic [1:0]  oss;
		logic [27:0] exp_temp[$];
		logic [31:0] exp_pres[$];
		logic        exp_flt[$];
		int          errors;

		function void clear_coefs();
			ac123 = '0; ac456 = '0; b1b2 = '0; mcmd = '0; oss = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [47:0] val);
			case (idx)
				bpc_pkg::REG_AC123: ac123 = val;
				bpc_pkg::REG_AC456: ac456 = val;
				bpc_pkg::REG_B1B2:  b1b2 = val[31:0];
				bpc_pkg::REG_MCMD:  mcmd = val[31:0];
				bpc_pkg::REG_OSS:   oss = val[1:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] asr(logic [31:0] v, int s);
			return $unsigned($signed(v) >>> s);
		endfunction

		function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
			longint sa, sb;
			sa = $signed(a);
			sb = $signed(b);
			return 32'(sa / sb);
		endfunction

		// note an accepted reading: compute and queue its compensated result
		function void note_reading(logic [15:0] ut16, logic [18:0] up19);
			logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
			logic [31:0] x1, x2, x3, dv, b5, b6, b3, b4, b7, p, sq, tmp, comp;
			ac1 = {{16{ac123[47]}}, ac123[47:32]};
			ac2 = {{16{ac123[31]}}, ac123[31:16]};
			ac3 = {{16{ac123[15]}}, ac123[15:0]};
			ac4 = {16'd0, ac456[47:32]};
			ac5 = {16'd0, ac456[31:16]};
			ac6 = {16'd0, ac456[15:0]};
			b1 = {{16{b1b2[31]}}, b1b2[31:16]};
			b2 = {{16{b1b2[15]}}, b1b2[15:0]};
			mc = {{16{mcmd[31]}}, mcmd[31:16]};
			md = {{16{mcmd[15]}}, mcmd[15:0]};
			ut = {16'd0, ut16};
			up = {13'd0, up19};
			x1 = asr((ut - ac6) * ac5, 15);
			dv = x1 + md;
			if (dv == 0) begin
				exp_temp.push_back('0); exp_pres.push_back('0); exp_flt.push_back(1'b1);
				return;
			end
			x2 = sdiv(mc << 11, dv);
			b5 = x1 + x2;
			tmp = asr(b5 + 32'd8, 4);
			b6 = b5 - 32'd4000;
			sq = asr(b6 * b6, 12);
			x1 = asr(b2 * sq, 11);
			x2 = asr(ac2 * b6, 11);
			x3 = x1 + x2;
			b3 = asr(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
			x1 = asr(ac3 * b6, 13);
			x2 = asr(b1 * sq, 16);
			x3 = asr(x1 + x2 + 32'd2, 2);
			b4 = (ac4 * (x3 + 32'd32768)) >> 15;
			if (b4 == 0) begin
				exp_temp.push_back('0); exp_pres.push_back('0); exp_flt.push_back(1'b1);
				return;
			end
			b7 = (up - b3) * (32'd50000 >> oss);
			if (b7 < 32'h80000000) p = (b7 << 1) / b4;
			else p = (b7 / b4) << 1;
			x1 = asr(p, 8) * asr(p, 8);
			x1 = asr(x1 * 32'd3038, 16);
			x2 = asr(32'd0 - 32'd7357 * p, 16);
			comp = p + asr(x1 + x2 + 32'd3791, 4);
			exp_temp.push_back(tmp[27:0]); exp_pres.push_back(comp); exp_flt.push_back(1'b0);
		endfunction

		function void check_result(logic [27:0] t, logic [31:0] pr, logic f);
			logic [27:0] et;
			logic [31:0] ep;
			logic        ef;
			if (exp_temp.size() == 0) begin
				$display("%0t: unexpected result t=%0d p=%0d f=%0b", $time,
					$signed(t), $signed(pr), f);
				errors++;
				return;
			end
			et = exp_temp.pop_front(); ep = exp_pres.pop_front(); ef = exp_flt.pop_front();
			if (t !== et) begin
				$display("%0t: temperature_tenths exp %0d got %0d", $time,
					$signed(et), $signed(t));
				errors++;
			end
			if (pr !== ep) begin
				$display("%0t: pressure_pa exp %0d got %0d", $time, $signed(ep), $signed(pr));
				errors++;
			end
			if (f !== ef) begin
				$display("%0t: divide_fault exp %0b got %0b", $time, ef, f);
				errors++;
			end
		endfunction

		function int pending();
			return exp_temp.size();
		endfunction
	endclass

	logic               clk, arst_n;
	logic               cfg_write;
	logic [2:0]         cfg_index;
	logic [47:0]        cfg_data;
	logic               in_valid, in_stall;
	logic [15:0]        raw_temperature;
	logic [18:0]        raw_pressure;
	logic               out_valid, out_stall;
	logic signed [27:0] temperature_tenths;
	logic signed [31:0] pressure_pa;
	logic               divide_fault;
	logic               rx_on;
	int                 rx_wait;

	comp_scoreboard sb;

	barometric_pressure_compensation_core dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL barometric_pressure_compensation_core");
		$finish;
	end

	// result side: check each accepted request, then randomly raise out_stall before the next while rx_on
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(temperature_tenths, pressure_pa, divide_fault);
			rx_wait = rx_on ? $urandom_range(0, 10) : 0;
			out_stall <= (rx_wait != 0);
		end else if (out_stall) begin
			if (rx_wait > 1)
				rx_wait--;
			else
				out_stall <= 1'b0;
		end
	end

	// registers are written only with the pipeline empty
	task automatic set_reg(logic [2:0] idx, logic [47:0] val);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_reading(logic [15:0] ut, logic [18:0] up, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1; raw_temperature <= ut; raw_pressure <= up;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_reading(ut, up);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// coefficient set close to a real sensor, with random jitter
	task automatic typical_coefs(logic [1:0] mode);
		set_reg(bpc_pkg::REG_AC123,
			{16'd408 + 16'($urandom_range(0, 64)), -16'sd72, -16'sd14383});
		set_reg(bpc_pkg::REG_AC456,
			{16'd32741, 16'd32757 - 16'($urandom_range(0, 500)), 16'd23153});
		set_reg(bpc_pkg::REG_B1B2, 48'({16'd6190, 16'd4}));
		set_reg(bpc_pkg::REG_MCMD, 48'({-16'sd8711, 16'd2868}));
		set_reg(bpc_pkg::REG_OSS, {46'd0, mode});
	endtask

	task automatic random_coefs();
		set_reg(bpc_pkg::REG_AC123, 48'({$urandom, $urandom}));
		set_reg(bpc_pkg::REG_AC456, 48'({$urandom, $urandom}));
		set_reg(bpc_pkg::REG_B1B2, {16'd0, $urandom});
		set_reg(bpc_pkg::REG_MCMD, {16'd0, $urandom});
		set_reg(bpc_pkg::REG_OSS, 48'($urandom_range(0, 3)));
	endtask

	initial begin
		int n;
		bit burst;
		sb = new();
		sb.clear_coefs();
		arst_n = 0; rx_on = 0; rx_wait = 0;
		cfg_write = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; raw_temperature = '0; raw_pressure = '0; out_stall = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		rx_on <= 1;

		// all-zero coefficients: temperature divisor zero -> fault
		send_reading(16'd0, 19'd0, 0);
		send_reading(16'hFFFF, 19'h7FFFF, 0);
		// ignored index
		set_reg(3'd7, '1);
		set_reg(3'd5, '1);
		// md nonzero but ac4 zero: pressure divisor zero
		set_reg(bpc_pkg::REG_MCMD, {16'd0, 16'd1, 16'd1});
		send_reading(16'd1234, 19'd5000, 0);
		typical_coefs(2'd0);
		send_reading(16'd27898, 19'd23843, 0);
		send_reading(16'd0, 19'd0, 0);
		send_reading(16'hFFFF, 19'h7FFFF, 0);
		// md cancels x1 = 0 (ut == ac6, md == 0) -> temperature fault
		set_reg(bpc_pkg::REG_MCMD, {16'd0, 16'h8000, 16'd0});
		send_reading(16'd23153, 19'd100, 0);
		drain();
		// extremes of every register
		set_reg(bpc_pkg::REG_AC123, '1); set_reg(bpc_pkg::REG_AC456, '1);
		set_reg(bpc_pkg::REG_B1B2, 48'hFFFF_FFFF); set_reg(bpc_pkg::REG_MCMD, 48'h7FFF_7FFF);
		set_reg(bpc_pkg::REG_OSS, 48'd3);
		send_reading(16'd0, 19'h7FFFF, 0);
		send_reading(16'hFFFF, 19'd0, 0);
		send_reading(16'h8000, 19'h40000, 0);
		set_reg(bpc_pkg::REG_AC123, 48'h8000_8000_8000);
		set_reg(bpc_pkg::REG_MCMD, 48'h8000_8000);
		send_reading(16'h5555, 19'h2AAAA, 0);
		send_reading(16'hAAAA, 19'h55555, 0);
		drain();

		// random phases: mostly realistic coefficients, some fully random
		for (int ph = 0; ph < 14; ph++) begin
			if (ph % 4 == 3) random_coefs();
			else typical_coefs(2'($urandom_range(0, 3)));
			n = 125;
			for (int i = 0; i < n; i++) begin
				burst = (i % 40) < 15;
				if ($urandom_range(0, 9) < 7)
					send_reading(16'($urandom_range(20000, 35000)),
						19'($urandom_range(10000, 120000) << sb.oss >> 1), burst);
				else
					send_reading(16'($urandom), 19'($urandom), burst);
				if (i == 60 && ph == 2)
					drain();
			end
			drain();
		end

		rx_on <= 0;
		drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS barometric_pressure_compensation_core");
		else
			$display("FAIL barometric_pressure_compensation_core");
		$finish;
	end

endmodule
